>>> rtl/fat_volume_label_probe_defines.svh
// Shared assertion macros for the probe checker.
`ifndef FAT_VOLUME_LABEL_PROBE_DEFINES_SVH
`define FAT_VOLUME_LABEL_PROBE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FVLP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define FVLP_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/fvlp_pkg.sv
package fvlp_pkg;

    localparam int LABEL_CHARS      = 11;
    localparam int MAX_SECTOR_BYTES = 4096;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_FAIL  = 2'd2;

    localparam logic [0:0] REG_SECTOR_BYTES = 1'b0;
    localparam logic [0:0] REG_LABEL_CAP    = 1'b1;

    typedef enum logic [2:0] {
        ST_READ      = 3'd0,
        ST_LABEL     = 3'd1,
        ST_BAD_SIZE  = 3'd2,
        ST_READ_FAIL = 3'd3,
        ST_NO_SIG    = 3'd4,
        ST_BAD_FAT   = 3'd5,
        ST_NOT_FAT   = 3'd6,
        ST_NO_NAME   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        NX_STAY = 2'd0,
        NX_IDLE = 2'd1,
        NX_BOOT = 2'd2,
        NX_DIR  = 2'd3
    } next_phase_t;

    typedef struct packed {
        logic start;
        logic boot_byte;
        logic dir_byte;
        logic fail;
        logic fail_in_dir;
    } cmd_t;

    typedef struct packed {
        logic        emit;
        next_phase_t next;
    } sts_t;

    // Character 0 in the lowest byte.
    localparam logic [8*LABEL_CHARS-1:0] NO_NAME_TEXT = "    EMAN ON";

    function automatic logic size_ok(input logic [15:0] s);
        logic ok;
        begin
            ok = (s == 16'd512) || (s == 16'd1024) || (s == 16'd2048) || (s == 16'd4096);
            size_ok = ok && (32'(s) <= 32'(MAX_SECTOR_BYTES));
        end
    endfunction

    function automatic logic [7:0] fat_char(input logic [1:0] idx);
        begin
            case (idx)
                2'd0:    fat_char = "F";
                2'd1:    fat_char = "A";
                default: fat_char = "T";
            endcase
        end
    endfunction

endpackage

>>> rtl/fat_volume_label_probe.sv
// A result is registered and shown in the cycle after the transfer of the item that causes it.
// Throughput: one item per cycle while results are taken; the output register
// holds one result and input stalls only while it waits on out_ready.
// The data offset multiply runs in the background on boot-sector bytes 40 to 42.
// Reset: asynchronous, active low; clears phase, output valid and registers to 512 and 12.
module fat_volume_label_probe
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] read_offset,
    output logic [12:0] read_length,
    output logic [63:0] label_first_eight,
    output logic [23:0] label_last_three,
    output logic [3:0]  label_length,
    output logic        is_fat32,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fvlp_pkg::cmd_t cmd;
    fvlp_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    fvlp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    fvlp_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .data_byte         (data_byte),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .status            (status),
        .read_offset       (read_offset),
        .read_length       (read_length),
        .label_first_eight (label_first_eight),
        .label_last_three  (label_last_three),
        .label_length      (label_length),
        .is_fat32          (is_fat32)
    );

endmodule

>>> rtl/fvlp_datapath.sv
module fvlp_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fvlp_pkg::cmd_t       cmd,
    output fvlp_pkg::sts_t       sts,
    input  logic [7:0]           data_byte,
    input  logic                 cfg_write,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output logic [2:0]           status,
    output logic [31:0]          read_offset,
    output logic [12:0]          read_length,
    output logic [63:0]          label_first_eight,
    output logic [23:0]          label_last_three,
    output logic [3:0]           label_length,
    output logic                 is_fat32
);

    logic [15:0] sector_bytes_reg;
    logic [6:0]  label_cap_reg;
    logic [12:0] pos_reg;
    logic [12:0] pos_next;
    logic [15:0] bps_reg;
    logic [15:0] rsvd_reg;
    logic [7:0]  nfats_reg;
    logic [15:0] fsz16_reg;
    logic [7:0]  sig_reg;
    logic [31:0] fsz32_reg;
    logic [1:0]  tmatch_reg;
    logic [1:0]  tmatch_next;
    logic [31:0] prod_reg;
    logic [31:0] fds_reg;
    logic [31:0] calc_off_reg;
    logic [31:0] dir_off_reg;
    logic [31:0] dir_off_next;
    logic [7:0]  efb_reg;
    logic [7:0]  label_mem [fvlp_pkg::LABEL_CHARS];

    logic [2:0]  status_reg;
    logic [31:0] read_offset_reg;
    logic [12:0] read_length_reg;
    logic [63:0] lo_reg;
    logic [23:0] hi_reg;
    logic [3:0]  len_reg;
    logic        f32_reg;

    fvlp_pkg::status_t res_status;
    logic [31:0] res_off;
    logic [12:0] res_len;
    logic        res_label;
    logic        res_f32;

    logic        fat16;
    logic        noname;
    logic [87:0] label_flat;
    logic [3:0]  lim;
    logic [3:0]  maxc;
    logic [3:0]  n_chars;
    logic [3:0]  n_trim;
    logic        stop;
    logic [87:0] label_out;
    logic [4:0]  entry_pos;
    logic [13:0] pos_inc;
    logic        in_label16;
    logic        in_label32;
    logic [3:0]  label_idx;

    assign fat16     = (fsz16_reg != 16'd0);
    assign entry_pos = pos_reg[4:0];
    assign pos_inc   = {1'b0, pos_reg} + 14'd1;

    always_comb
    begin
        for (int i = 0; i < fvlp_pkg::LABEL_CHARS; i++)
        begin
            label_flat[8*i +: 8] = label_mem[i];
        end
    end

    assign noname = (label_flat == fvlp_pkg::NO_NAME_TEXT);

    always_comb
    begin
        lim = (label_cap_reg > 7'd12) ? 4'd12 : label_cap_reg[3:0];
        maxc = (lim == 4'd0) ? 4'd0 : lim - 4'd1;
        n_chars = 4'd0;
        stop = 1'b0;
        for (int i = 0; i < fvlp_pkg::LABEL_CHARS; i++)
        begin
            if (!stop)
            begin
                if ((4'(i) < maxc) && (label_mem[i] != 8'd0))
                    n_chars = 4'(i + 1);
                else
                    stop = 1'b1;
            end
        end
        n_trim = (n_chars != 4'd0) ? 4'd1 : 4'd0;
        for (int j = 0; j < fvlp_pkg::LABEL_CHARS; j++)
        begin
            if ((4'(j) < n_chars) && (label_mem[j] != 8'h20))
                n_trim = 4'(j + 1);
        end
        for (int k = 0; k < fvlp_pkg::LABEL_CHARS; k++)
        begin
            label_out[8*k +: 8] = (4'(k) < n_trim) ? label_mem[k] : 8'd0;
        end
    end

    always_comb
    begin
        sts.emit     = 1'b0;
        sts.next     = fvlp_pkg::NX_STAY;
        res_status   = fvlp_pkg::ST_READ;
        res_off      = 32'd0;
        res_len      = 13'd0;
        res_label    = 1'b0;
        res_f32      = 1'b0;
        pos_next     = pos_reg;
        dir_off_next = dir_off_reg;
        if (cmd.start)
        begin
            sts.emit = 1'b1;
            if (fvlp_pkg::size_ok(sector_bytes_reg))
            begin
                sts.next = fvlp_pkg::NX_BOOT;
                res_len  = sector_bytes_reg[12:0];
                pos_next = 13'd0;
            end
            else
            begin
                sts.next   = fvlp_pkg::NX_IDLE;
                res_status = fvlp_pkg::ST_BAD_SIZE;
            end
        end
        else if (cmd.fail)
        begin
            sts.emit   = 1'b1;
            sts.next   = fvlp_pkg::NX_IDLE;
            res_status = fvlp_pkg::ST_READ_FAIL;
            res_f32    = cmd.fail_in_dir;
        end
        else if (cmd.boot_byte)
        begin
            if (pos_reg == 13'd511)
            begin
                sts.emit = 1'b1;
                sts.next = fvlp_pkg::NX_IDLE;
                if (sig_reg != 8'h55 || data_byte != 8'hAA)
                    res_status = fvlp_pkg::ST_NO_SIG;
                else if (fat16)
                begin
                    if (!tmatch_reg[0])
                        res_status = fvlp_pkg::ST_BAD_FAT;
                    else if (noname)
                        res_status = fvlp_pkg::ST_NO_NAME;
                    else
                    begin
                        res_status = fvlp_pkg::ST_LABEL;
                        res_label  = 1'b1;
                    end
                end
                else if (fsz32_reg == 32'd0)
                    res_status = fvlp_pkg::ST_NOT_FAT;
                else
                begin
                    res_f32 = 1'b1;
                    if (!tmatch_reg[1])
                        res_status = fvlp_pkg::ST_BAD_FAT;
                    else if (!noname)
                    begin
                        res_status = fvlp_pkg::ST_LABEL;
                        res_label  = 1'b1;
                    end
                    else if (!fvlp_pkg::size_ok(bps_reg))
                        res_status = fvlp_pkg::ST_BAD_FAT;
                    else
                    begin
                        sts.next     = fvlp_pkg::NX_DIR;
                        res_off      = calc_off_reg;
                        res_len      = bps_reg[12:0];
                        dir_off_next = calc_off_reg;
                        pos_next     = 13'd0;
                    end
                end
            end
            else
            begin
                pos_next = pos_inc[12:0];
            end
        end
        else if (cmd.dir_byte)
        begin
            if (entry_pos == 5'd0 && data_byte == 8'd0)
            begin
                sts.emit   = 1'b1;
                sts.next   = fvlp_pkg::NX_IDLE;
                res_status = fvlp_pkg::ST_NO_NAME;
                res_f32    = 1'b1;
            end
            else if (entry_pos == 5'd11 && efb_reg != 8'hE5 && data_byte[3:0] != 4'hF
                     && data_byte[3])
            begin
                sts.emit   = 1'b1;
                sts.next   = fvlp_pkg::NX_IDLE;
                res_status = fvlp_pkg::ST_LABEL;
                res_label  = 1'b1;
                res_f32    = 1'b1;
            end
            else if ({2'b00, pos_inc} >= bps_reg)
            begin
                sts.emit     = 1'b1;
                dir_off_next = dir_off_reg + {16'd0, bps_reg};
                res_off      = dir_off_next;
                res_len      = bps_reg[12:0];
                res_f32      = 1'b1;
                pos_next     = 13'd0;
            end
            else
            begin
                pos_next = pos_inc[12:0];
            end
        end
    end

    always_comb
    begin
        tmatch_next = tmatch_reg;
        if (pos_reg >= 13'd54 && pos_reg < 13'd57
            && data_byte != fvlp_pkg::fat_char(2'(pos_reg - 13'd54)))
            tmatch_next[0] = 1'b0;
        if (pos_reg >= 13'd82 && pos_reg < 13'd85
            && data_byte != fvlp_pkg::fat_char(2'(pos_reg - 13'd82)))
            tmatch_next[1] = 1'b0;
    end

    assign in_label16 = fat16 && pos_reg >= 13'd43 && pos_reg < 13'd54;
    assign in_label32 = !fat16 && pos_reg >= 13'd71 && pos_reg < 13'd82;
    assign label_idx  = in_label16 ? 4'(pos_reg - 13'd43) : 4'(pos_reg - 13'd71);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_bytes_reg <= 16'd512;
            label_cap_reg    <= 7'd12;
            pos_reg          <= 13'd0;
            bps_reg          <= 16'd0;
            rsvd_reg         <= 16'd0;
            nfats_reg        <= 8'd0;
            fsz16_reg        <= 16'd0;
            sig_reg          <= 8'd0;
            fsz32_reg        <= 32'd0;
            tmatch_reg       <= 2'd0;
            dir_off_reg      <= 32'd0;
            efb_reg          <= 8'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    fvlp_pkg::REG_SECTOR_BYTES: sector_bytes_reg <= cfg_data;
                    fvlp_pkg::REG_LABEL_CAP:    label_cap_reg    <= cfg_data[6:0];
                    default:                    ;
                endcase
            end
            pos_reg     <= pos_next;
            dir_off_reg <= dir_off_next;
            if (cmd.start)
            begin
                bps_reg    <= 16'd0;
                rsvd_reg   <= 16'd0;
                nfats_reg  <= 8'd0;
                fsz16_reg  <= 16'd0;
                sig_reg    <= 8'd0;
                fsz32_reg  <= 32'd0;
                tmatch_reg <= 2'b11;
            end
            else if (cmd.boot_byte)
            begin
                tmatch_reg <= tmatch_next;
                case (pos_reg)
                    13'd11:  bps_reg[7:0]     <= data_byte;
                    13'd12:  bps_reg[15:8]    <= data_byte;
                    13'd14:  rsvd_reg[7:0]    <= data_byte;
                    13'd15:  rsvd_reg[15:8]   <= data_byte;
                    13'd16:  nfats_reg        <= data_byte;
                    13'd22:  fsz16_reg[7:0]   <= data_byte;
                    13'd23:  fsz16_reg[15:8]  <= data_byte;
                    13'd36:  fsz32_reg[7:0]   <= data_byte;
                    13'd37:  fsz32_reg[15:8]  <= data_byte;
                    13'd38:  fsz32_reg[23:16] <= data_byte;
                    13'd39:  fsz32_reg[31:24] <= data_byte;
                    13'd510: sig_reg          <= data_byte;
                    default: ;
                endcase
            end
            else if (cmd.dir_byte && entry_pos == 5'd0)
            begin
                efb_reg <= data_byte;
            end
        end
    end

    // Offset of the first data sector, worked out while the boot sector streams past.
    always_ff @(posedge clk)
    begin
        if (cmd.boot_byte)
        begin
            case (pos_reg)
                13'd40:  prod_reg     <= 32'(nfats_reg * fsz32_reg);
                13'd41:  fds_reg      <= {16'd0, rsvd_reg} + prod_reg;
                13'd42:  calc_off_reg <= 32'(bps_reg * fds_reg);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.boot_byte && (in_label16 || in_label32))
            label_mem[label_idx] <= data_byte;
        else if (cmd.dir_byte && entry_pos < 5'd11)
            label_mem[entry_pos[3:0]] <= data_byte;
    end

    always_ff @(posedge clk)
    begin
        if (sts.emit)
        begin
            status_reg      <= res_status;
            read_offset_reg <= res_off;
            read_length_reg <= res_len;
            lo_reg          <= res_label ? label_out[63:0] : 64'd0;
            hi_reg          <= res_label ? label_out[87:64] : 24'd0;
            len_reg         <= res_label ? n_trim : 4'd0;
            f32_reg         <= res_f32;
        end
    end

    assign status            = status_reg;
    assign read_offset       = read_offset_reg;
    assign read_length       = read_length_reg;
    assign label_first_eight = lo_reg;
    assign label_last_three  = hi_reg;
    assign label_length      = len_reg;
    assign is_fat32          = f32_reg;

endmodule

>>> rtl/fvlp_ctrl.sv
module fvlp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     action,
    output logic           out_valid,
    input  logic           out_ready,
    output fvlp_pkg::cmd_t cmd,
    input  fvlp_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_BOOT = 3'b010,
        PH_DIR  = 3'b100
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        cmd.start       = in_xfer && action == fvlp_pkg::ACT_START;
        cmd.boot_byte   = in_xfer && action == fvlp_pkg::ACT_DATA && phase_reg == PH_BOOT;
        cmd.dir_byte    = in_xfer && action == fvlp_pkg::ACT_DATA && phase_reg == PH_DIR;
        cmd.fail        = in_xfer && action == fvlp_pkg::ACT_FAIL && phase_reg != PH_IDLE;
        cmd.fail_in_dir = phase_reg == PH_DIR;
    end

    always_comb
    begin
        case (sts.next)
            fvlp_pkg::NX_IDLE: phase_next = PH_IDLE;
            fvlp_pkg::NX_BOOT: phase_next = PH_BOOT;
            fvlp_pkg::NX_DIR:  phase_next = PH_DIR;
            default:           phase_next = phase_reg;
        endcase
        out_valid_next = sts.emit || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/fvlp_checker.sv
`include "fat_volume_label_probe_defines.svh"

module fvlp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  action,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [12:0] read_length,
    input logic [3:0]  label_length
);

    `FVLP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `FVLP_ASSERT(a_start_result, in_valid && in_ready && action == fvlp_pkg::ACT_START |=> out_valid && (status == fvlp_pkg::ST_READ || status == fvlp_pkg::ST_BAD_SIZE), "start transfer gave no request or size status")
    `FVLP_NEVER(a_len_on_status, out_valid && status != fvlp_pkg::ST_READ && read_length != 13'd0, "read length on a non-request result")
    `FVLP_NEVER(a_label_len, out_valid && status != fvlp_pkg::ST_LABEL && label_length != 4'd0, "label length on a non-label result")

endmodule

bind fat_volume_label_probe fvlp_checker u_fvlp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .read_length  (read_length),
    .label_length (label_length)
);
